// ----- src/ssms_pkg.sv -----
package ssms_pkg;

    localparam int unsigned MESSAGE_BYTES_MAX_DEF = 11;
    localparam int unsigned QUEUE_DEPTH_DEF       = 2;

    localparam int unsigned DWELL_W     = 16;
    localparam int unsigned SEG_W       = 8;
    localparam int unsigned DIGIT_W     = 5;
    localparam int unsigned KIND_W      = 2;
    localparam int unsigned GLYPH_SEG_W = 7;

    localparam logic [DWELL_W-1:0] DWELL_RESET = 16'd1;

    // request types
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_SCAN   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;

    // display layout
    localparam int unsigned GLYPHS_MAX = 4;
    localparam int unsigned POS_FIFTH  = 4;
    localparam int unsigned SLOTS_LIT  = 5;
    localparam int unsigned SLOT_LAST  = 5;
    localparam int unsigned SLOT_W     = 3;

    localparam logic [SEG_W-1:0] SEG_COLON  = 8'h03;
    localparam logic [SEG_W-1:0] SEG_DEGREE = 8'h04;
    localparam logic [SEG_W-1:0] SEG_DP     = 8'h80;

    typedef struct packed {
        logic       req_type;
        logic [7:0] message_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [KIND_W-1:0]  result_kind;
        logic [SEG_W-1:0]   segment_drive;
        logic [DIGIT_W-1:0] digit_enable;
    } out_item_t;

    // classified transaction as held in the queue
    typedef struct packed {
        logic                   req_type;
        logic                   last_byte;
        logic                   is_zero;
        logic                   is_dot;
        logic                   is_colon;
        logic                   is_deg_lead;
        logic                   is_deg_tail;
        logic                   rom_hit;
        logic [GLYPH_SEG_W-1:0] rom_seg;
    } cls_item_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic      valid;
        cls_item_t item;
    } q_head_t;

endpackage

// ----- src/ssms_front.sv -----
module ssms_front (
    input  ssms_pkg::in_item_t  s_data,
    output ssms_pkg::cls_item_t cls_item
);

    localparam logic [7:0] CHAR_DOT      = 8'h2E;
    localparam logic [7:0] CHAR_COLON    = 8'h3A;
    localparam logic [7:0] CHAR_DEG_LEAD = 8'd194;
    localparam logic [7:0] CHAR_DEG_TAIL = 8'd176;

    // character rom: {hit, segments a..g}
    function automatic logic [ssms_pkg::GLYPH_SEG_W:0] glyph_rom(input logic [7:0] c);
        logic [ssms_pkg::GLYPH_SEG_W:0] r;
        begin
            case (c)
                "0": r = {1'b1, 7'h3F};
                "1": r = {1'b1, 7'h06};
                "2": r = {1'b1, 7'h5B};
                "3": r = {1'b1, 7'h4F};
                "4": r = {1'b1, 7'h66};
                "5": r = {1'b1, 7'h6D};
                "6": r = {1'b1, 7'h7D};
                "7": r = {1'b1, 7'h07};
                "8": r = {1'b1, 7'h7F};
                "9": r = {1'b1, 7'h6F};
                "A": r = {1'b1, 7'h77};
                "B": r = {1'b1, 7'h7C};
                "C": r = {1'b1, 7'h39};
                "D": r = {1'b1, 7'h5E};
                "E": r = {1'b1, 7'h79};
                "F": r = {1'b1, 7'h71};
                "G": r = {1'b1, 7'h3D};
                "H": r = {1'b1, 7'h76};
                "I": r = {1'b1, 7'h06};
                "J": r = {1'b1, 7'h0F};
                "L": r = {1'b1, 7'h38};
                "N": r = {1'b1, 7'h54};
                "O": r = {1'b1, 7'h5C};
                "P": r = {1'b1, 7'h73};
                "Q": r = {1'b1, 7'h67};
                "S": r = {1'b1, 7'h6D};
                "U": r = {1'b1, 7'h3E};
                "Y": r = {1'b1, 7'h6E};
                "_": r = {1'b1, 7'h08};
                " ": r = {1'b1, 7'h00};
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    logic [ssms_pkg::GLYPH_SEG_W:0] rom_out;

    assign rom_out = glyph_rom(s_data.message_byte);

    always_comb begin
        cls_item.req_type    = s_data.req_type;
        cls_item.last_byte   = s_data.last_byte;
        cls_item.is_zero     = (s_data.message_byte == 8'd0);
        cls_item.is_dot      = (s_data.message_byte == CHAR_DOT);
        cls_item.is_colon    = (s_data.message_byte == CHAR_COLON);
        cls_item.is_deg_lead = (s_data.message_byte == CHAR_DEG_LEAD);
        cls_item.is_deg_tail = (s_data.message_byte == CHAR_DEG_TAIL);
        cls_item.rom_hit     = rom_out[ssms_pkg::GLYPH_SEG_W];
        cls_item.rom_seg     = rom_out[ssms_pkg::GLYPH_SEG_W-1:0];
    end

endmodule

// ----- src/ssms_queue.sv -----
module ssms_queue #(
    parameter int unsigned DEPTH = ssms_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  ssms_pkg::cls_item_t        push_item,
    input  logic                       pop,
    output ssms_pkg::q_head_t          head,
    output logic                       full,
    output logic [$clog2(DEPTH+1)-1:0] level
);

    localparam int unsigned PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned LEVEL_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]   PTR_LAST   = PTR_W'(DEPTH - 1);
    localparam logic [LEVEL_W-1:0] LEVEL_FULL = LEVEL_W'(DEPTH);

    ssms_pkg::cls_item_t mem [DEPTH];

    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [LEVEL_W-1:0] level_reg,  level_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            level_next = level_reg + 1'b1;
        end else if (pop && !push) begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    assign head.valid = (level_reg != '0);
    assign head.item  = mem[rd_ptr_reg];
    assign full       = (level_reg == LEVEL_FULL);
    assign level      = level_reg;

endmodule

// ----- src/ssms_back.sv -----
module ssms_back #(
    parameter int unsigned MESSAGE_BYTES_MAX = ssms_pkg::MESSAGE_BYTES_MAX_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [ssms_pkg::DWELL_W-1:0]     cfg_wr_data,
    input  ssms_pkg::q_head_t                head,
    output logic                             pop,
    output logic                             m_valid,
    input  logic                             m_ready,
    output ssms_pkg::out_item_t              m_data
);

    localparam int unsigned BC_W = $clog2(MESSAGE_BYTES_MAX + 1);
    localparam logic [BC_W-1:0] BC_MAX = BC_W'(MESSAGE_BYTES_MAX);

    localparam logic [2:0] PH_EXPECT  = 3'd0;
    localparam logic [2:0] PH_AFTER   = 3'd1;
    localparam logic [2:0] PH_DEG2    = 3'd2;
    localparam logic [2:0] PH_DONE    = 3'd3;
    localparam logic [2:0] PH_ENDED   = 3'd4;
    localparam logic [2:0] PH_INVALID = 3'd5;

    localparam int unsigned SEG_W = ssms_pkg::SEG_W;
    localparam int unsigned SL_W  = ssms_pkg::SLOT_W;
    localparam logic [2:0]      GLYPHS_MAX = 3'(ssms_pkg::GLYPHS_MAX);
    localparam logic [SL_W-1:0] POS_FIFTH  = SL_W'(ssms_pkg::POS_FIFTH);
    localparam logic [SL_W-1:0] SLOTS_LIT  = SL_W'(ssms_pkg::SLOTS_LIT);
    localparam logic [SL_W-1:0] SLOT_LAST  = SL_W'(ssms_pkg::SLOT_LAST);

    ssms_pkg::cls_item_t item;

    logic [ssms_pkg::DWELL_W-1:0] dwell_ticks_reg;
    logic [2:0]       phase_reg,  phase_next;
    logic [2:0]       gc_reg,     gc_next;
    logic [BC_W-1:0]  bc_reg,     bc_next;
    logic [2:0]       used_reg,   used_next;
    logic [SEG_W-1:0] staged_reg [5];
    logic [SEG_W-1:0] staged_next [5];
    logic [SEG_W-1:0] shown_reg [5];
    logic [SEG_W-1:0] shown_next [5];
    logic [2:0]       shown_used_reg, shown_used_next;
    logic [SL_W-1:0]  slot_reg,   slot_next;
    logic [ssms_pkg::DWELL_W-1:0] dwell_cnt_reg, dwell_cnt_next;

    logic                out_valid_reg;
    ssms_pkg::out_item_t out_data_reg, out_data_next;
    logic                has_result;

    // parse and scan scratch
    logic [2:0]       ph_eff;
    logic [2:0]       g;
    logic             run_expect;
    logic [2:0]       dot_idx;
    logic [SL_W-1:0]  s;
    logic [SL_W-1:0]  nx;
    logic [ssms_pkg::DWELL_W-1:0] limit;
    logic [ssms_pkg::DWELL_W:0]   cnt_inc;
    logic             msg_ok;

    assign item       = head.item;
    assign has_result = (item.req_type == ssms_pkg::REQ_TICK) || item.last_byte;
    assign pop        = head.valid && (!out_valid_reg || m_ready || !has_result);

    always_comb begin
        phase_next      = phase_reg;
        gc_next         = gc_reg;
        bc_next         = bc_reg;
        used_next       = used_reg;
        staged_next     = staged_reg;
        shown_next      = shown_reg;
        shown_used_next = shown_used_reg;
        slot_next       = slot_reg;
        dwell_cnt_next  = dwell_cnt_reg;
        out_data_next   = '0;
        ph_eff          = phase_reg;
        g               = gc_reg;
        run_expect      = 1'b0;
        dot_idx         = {1'b0, 2'(used_reg - 3'd1)};
        s               = slot_reg;
        nx              = '0;
        limit           = ssms_pkg::DWELL_RESET;
        cnt_inc         = '0;
        msg_ok          = 1'b0;

        if (pop) begin
            if (item.req_type == ssms_pkg::REQ_TICK) begin
                // scan tick
                limit = (dwell_ticks_reg == '0) ? ssms_pkg::DWELL_RESET : dwell_ticks_reg;
                if (s > SLOT_LAST) begin
                    s = '0;
                end
                if (s < POS_FIFTH && s >= shown_used_reg) begin
                    s = POS_FIFTH;
                end
                out_data_next.result_kind   = ssms_pkg::KIND_SCAN;
                out_data_next.segment_drive = (s < SLOTS_LIT) ? shown_reg[s] : '0;
                out_data_next.digit_enable  = (s < SLOTS_LIT) ?
                    (ssms_pkg::DIGIT_W'(1) << s) : '0;
                cnt_inc = {1'b0, dwell_cnt_reg} + 1'b1;
                if (cnt_inc >= {1'b0, limit}) begin
                    dwell_cnt_next = '0;
                    nx = s + 1'b1;
                    if (nx > SLOT_LAST) begin
                        nx = '0;
                    end
                    if (nx < POS_FIFTH && nx >= shown_used_reg) begin
                        nx = POS_FIFTH;
                    end
                    slot_next = nx;
                end else begin
                    dwell_cnt_next = cnt_inc[ssms_pkg::DWELL_W-1:0];
                    slot_next      = s;
                end
            end else if (!item.last_byte) begin
                // content byte
                if (bc_reg >= BC_MAX) begin
                    ph_eff     = PH_INVALID;
                    phase_next = PH_INVALID;
                end else begin
                    bc_next = bc_reg + 1'b1;
                end
                case (ph_eff)
                    PH_DEG2: begin
                        if (item.is_deg_tail) begin
                            staged_next[4] = staged_reg[4] | ssms_pkg::SEG_DEGREE;
                            phase_next     = PH_EXPECT;
                        end else begin
                            phase_next = PH_INVALID;
                        end
                    end
                    PH_AFTER: begin
                        g       = gc_reg + 3'd1;
                        gc_next = g;
                        if (item.is_dot && used_reg != 3'd0) begin
                            staged_next[dot_idx] = staged_reg[dot_idx] | ssms_pkg::SEG_DP;
                            phase_next = (g >= GLYPHS_MAX) ? PH_DONE : PH_EXPECT;
                        end else if (g >= GLYPHS_MAX) begin
                            phase_next = item.is_zero ? PH_ENDED : PH_INVALID;
                        end else begin
                            run_expect = 1'b1;
                        end
                    end
                    PH_DONE: begin
                        phase_next = item.is_zero ? PH_ENDED : PH_INVALID;
                    end
                    PH_EXPECT: begin
                        run_expect = 1'b1;
                    end
                    default: begin
                    end
                endcase
                if (run_expect) begin
                    if (item.is_zero) begin
                        phase_next = PH_ENDED;
                    end else if (g == 3'd2 && item.is_colon) begin
                        staged_next[4] = staged_reg[4] | ssms_pkg::SEG_COLON;
                        phase_next     = PH_EXPECT;
                    end else if (g == 3'd3 && item.is_deg_lead) begin
                        phase_next = PH_DEG2;
                    end else if (!item.rom_hit || g >= GLYPHS_MAX) begin
                        phase_next = PH_INVALID;
                    end else begin
                        staged_next[{1'b0, g[1:0]}] = {1'b0, item.rom_seg};
                        used_next  = g + 3'd1;
                        phase_next = PH_AFTER;
                    end
                end
            end else begin
                // terminator: commit or drop, then restart staging
                msg_ok = (phase_reg inside {PH_EXPECT, PH_AFTER, PH_DONE, PH_ENDED});
                if (msg_ok) begin
                    shown_next      = staged_reg;
                    shown_used_next = (used_reg > GLYPHS_MAX) ? GLYPHS_MAX : used_reg;
                end
                phase_next = PH_EXPECT;
                gc_next    = '0;
                bc_next    = '0;
                used_next  = '0;
                for (int i = 0; i < 5; i++) begin
                    staged_next[i] = '0;
                end
                out_data_next.result_kind = msg_ok ? ssms_pkg::KIND_ACCEPT
                                                   : ssms_pkg::KIND_REJECT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dwell_ticks_reg <= ssms_pkg::DWELL_RESET;
            phase_reg       <= PH_EXPECT;
            gc_reg          <= '0;
            bc_reg          <= '0;
            used_reg        <= '0;
            shown_used_reg  <= '0;
            slot_reg        <= '0;
            dwell_cnt_reg   <= '0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < 5; i++) begin
                staged_reg[i] <= '0;
                shown_reg[i]  <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                dwell_ticks_reg <= cfg_wr_data;
            end
            phase_reg      <= phase_next;
            gc_reg         <= gc_next;
            bc_reg         <= bc_next;
            used_reg       <= used_next;
            shown_used_reg <= shown_used_next;
            slot_reg       <= slot_next;
            dwell_cnt_reg  <= dwell_cnt_next;
            staged_reg     <= staged_next;
            shown_reg      <= shown_next;
            if (pop && has_result) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && has_result) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// ----- src/seven_segment_message_scanner.sv -----
// a result passes a queue entry and then the output register before it shows on m_valid
// one transaction in and one queue entry retired per cycle, unless a result stalls
// message bytes other than the last give no result and retire even while the output stalls
// reset (aresetn low, synchronous): queue empty, staging cleared, display blank,
// scan at position one, dwell_ticks back to 1
module seven_segment_message_scanner #(
    parameter int unsigned MESSAGE_BYTES_MAX = ssms_pkg::MESSAGE_BYTES_MAX_DEF,
    parameter int unsigned QUEUE_DEPTH       = ssms_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration: dwell_ticks
    input  logic                         cfg_wr_en,
    input  logic [ssms_pkg::DWELL_W-1:0] cfg_wr_data,
    // request transactions
    input  logic                         s_valid,
    output logic                         s_ready,
    input  ssms_pkg::in_item_t           s_data,
    // result transactions
    output logic                         m_valid,
    input  logic                         m_ready,
    output ssms_pkg::out_item_t          m_data
);

    localparam int unsigned LEVEL_W = $clog2(QUEUE_DEPTH + 1);

    ssms_pkg::cls_item_t cls_item;
    ssms_pkg::q_head_t   q_head;
    logic                q_full;
    logic [LEVEL_W-1:0]  q_level;
    logic                push;
    logic                pop;

    // front end: rom lookup and byte classification, done on the way into the queue
    ssms_front u_front (
        .s_data   (s_data),
        .cls_item (cls_item)
    );

    // accept whenever the queue has room, independent of the output side
    assign s_ready = !q_full;
    assign push    = s_valid && s_ready;

    // short queue decoupling classification from parsing and scanning
    ssms_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (cls_item),
        .pop       (pop),
        .head      (q_head),
        .full      (q_full),
        .level     (q_level)
    );

    // back end: message parser, shown patterns, scan sequencer, output register
    ssms_back #(
        .MESSAGE_BYTES_MAX (MESSAGE_BYTES_MAX)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .head        (q_head),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

`ifndef SYNTHESIS
    // a scan drive lights at most one position
    a_scan_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.result_kind == ssms_pkg::KIND_SCAN) |->
            $onehot0(m_data.digit_enable))
        else $error("scan drive enables more than one position");

    // verdict transactions carry no drive
    a_verdict_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.result_kind != ssms_pkg::KIND_SCAN) |->
            (m_data.segment_drive == '0 && m_data.digit_enable == '0))
        else $error("verdict transaction carries segment or digit drive");

    // queue grows by one on a push without a pop
    a_queue_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && push && !pop) |=> (q_level == $past(q_level) + 1'b1))
        else $error("queue level did not follow a push");

    // the back end never retires from an empty queue
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> q_head.valid)
        else $error("pop from empty queue");
`endif

endmodule

// ----- tb/seven_segment_message_scanner_checker.sv -----
module seven_segment_message_scanner_checker
    import ssms_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [DWELL_W-1:0] cfg_wr_data,
    input  logic               s_valid,
    input  logic               s_ready,
    input  in_item_t           s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  out_item_t          m_data,
    output int                 mismatch_count,
    output int                 expected_left
);

    localparam int unsigned REPORT_LIMIT = 10;
    localparam int unsigned COLON_GLYPH  = 2;
    localparam int unsigned DEGREE_GLYPH = 3;

    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_DEG_LEAD = 8'd194;
    localparam logic [7:0] CH_DEG_TAIL = 8'd176;

    typedef enum logic [2:0] {
        PH_GLYPH,
        PH_AFTER_GLYPH,
        PH_DEGREE_TAIL,
        PH_FULL,
        PH_ENDED,
        PH_BROKEN
    } parse_phase_t;

    // display model
    logic [DWELL_W-1:0] dwell_ticks;
    parse_phase_t       phase;
    int unsigned        glyph_count;
    int unsigned        byte_count;
    logic [SEG_W-1:0]   staged_pat [SLOTS_LIT];
    int unsigned        staged_used;
    logic [SEG_W-1:0]   shown_pat [SLOTS_LIT];
    int unsigned        shown_used;
    int unsigned        scan_slot;
    int unsigned        dwell_count;

    out_item_t scan_results_q [$];
    int        fails = 0;

    assign mismatch_count = fails;

    // segment pattern of one character, hit low when it has none
    function automatic logic [SEG_W-1:0] glyph_pattern(input logic [7:0] c, output logic hit);
        hit = 1'b1;
        case (c)
            "0":     return 8'h3F;
            "1":     return 8'h06;
            "2":     return 8'h5B;
            "3":     return 8'h4F;
            "4":     return 8'h66;
            "5":     return 8'h6D;
            "6":     return 8'h7D;
            "7":     return 8'h07;
            "8":     return 8'h7F;
            "9":     return 8'h6F;
            "A":     return 8'h77;
            "B":     return 8'h7C;
            "C":     return 8'h39;
            "D":     return 8'h5E;
            "E":     return 8'h79;
            "F":     return 8'h71;
            "G":     return 8'h3D;
            "H":     return 8'h76;
            "I":     return 8'h06;
            "J":     return 8'h0F;
            "L":     return 8'h38;
            "N":     return 8'h54;
            "O":     return 8'h5C;
            "P":     return 8'h73;
            "Q":     return 8'h67;
            "S":     return 8'h6D;
            "U":     return 8'h3E;
            "Y":     return 8'h6E;
            "_":     return 8'h08;
            " ":     return 8'h00;
            default: begin
                hit = 1'b0;
                return 8'h00;
            end
        endcase
    endfunction

    task automatic clear_staging();
        phase       = PH_GLYPH;
        glyph_count = 0;
        byte_count  = 0;
        staged_used = 0;
        foreach (staged_pat[i]) staged_pat[i] = '0;
    endtask

    task automatic reset_display();
        dwell_ticks = DWELL_RESET;
        clear_staging();
        foreach (shown_pat[i]) shown_pat[i] = '0;
        shown_used  = 0;
        scan_slot   = 0;
        dwell_count = 0;
    endtask

    task automatic parse_byte(input logic [7:0] c);
        logic [SEG_W-1:0] seg;
        logic             hit;
        bit               again;
        again = 1'b1;
        while (again) begin
            again = 1'b0;
            case (phase)
                PH_DEGREE_TAIL: begin
                    if (c == CH_DEG_TAIL) begin
                        staged_pat[POS_FIFTH] |= SEG_DEGREE;
                        phase = PH_GLYPH;
                    end else begin
                        phase = PH_BROKEN;
                    end
                end
                PH_AFTER_GLYPH: begin
                    // a dot closes the glyph, anything else closes it and is parsed again
                    if (c == CH_DOT && staged_used > 0) begin
                        staged_pat[staged_used - 1] |= SEG_DP;
                    end else begin
                        again = 1'b1;
                    end
                    glyph_count++;
                    phase = (glyph_count >= GLYPHS_MAX) ? PH_FULL : PH_GLYPH;
                end
                PH_FULL: begin
                    phase = (c == CH_NUL) ? PH_ENDED : PH_BROKEN;
                end
                PH_GLYPH: begin
                    if (c == CH_NUL) begin
                        phase = PH_ENDED;
                    end else if (glyph_count == COLON_GLYPH && c == CH_COLON) begin
                        staged_pat[POS_FIFTH] |= SEG_COLON;
                    end else if (glyph_count == DEGREE_GLYPH && c == CH_DEG_LEAD) begin
                        phase = PH_DEGREE_TAIL;
                    end else begin
                        seg = glyph_pattern(c, hit);
                        if (!hit || glyph_count >= GLYPHS_MAX) begin
                            phase = PH_BROKEN;
                        end else begin
                            staged_pat[glyph_count] = seg;
                            staged_used = glyph_count + 1;
                            phase = PH_AFTER_GLYPH;
                        end
                    end
                end
                default: ;
            endcase
        end
    endtask

    // apply one request to the model and queue what it should produce
    task automatic predict_request(input in_item_t req);
        out_item_t   res;
        int unsigned limit;
        int unsigned nxt;
        bit          ok;
        res = '0;
        if (req.req_type == REQ_TICK) begin
            limit = (dwell_ticks == 0) ? 1 : dwell_ticks;
            if (scan_slot > SLOT_LAST) scan_slot = 0;
            if (scan_slot < GLYPHS_MAX && scan_slot >= shown_used) scan_slot = POS_FIFTH;
            res.result_kind = KIND_SCAN;
            if (scan_slot < SLOTS_LIT) begin
                res.segment_drive = shown_pat[scan_slot];
                res.digit_enable[scan_slot] = 1'b1;
            end
            dwell_count++;
            if (dwell_count >= limit) begin
                dwell_count = 0;
                nxt = (scan_slot + 1 > SLOT_LAST) ? 0 : scan_slot + 1;
                if (nxt < GLYPHS_MAX && nxt >= shown_used) nxt = POS_FIFTH;
                scan_slot = nxt;
            end
            scan_results_q.push_back(res);
        end else if (!req.last_byte) begin
            if (byte_count >= MESSAGE_BYTES_MAX_DEF) phase = PH_BROKEN;
            else byte_count++;
            parse_byte(req.message_byte);
        end else begin
            ok = (phase == PH_GLYPH) || (phase == PH_AFTER_GLYPH) ||
                 (phase == PH_FULL) || (phase == PH_ENDED);
            if (ok) begin
                foreach (shown_pat[i]) shown_pat[i] = staged_pat[i];
                shown_used = (staged_used > GLYPHS_MAX) ? GLYPHS_MAX : staged_used;
            end
            clear_staging();
            res.result_kind = ok ? KIND_ACCEPT : KIND_REJECT;
            scan_results_q.push_back(res);
        end
    endtask

    task automatic compare_result(input out_item_t got);
        out_item_t want;
        if (scan_results_q.size() == 0) begin
            fails++;
            if (fails <= REPORT_LIMIT)
                $display("%0t: unexpected result kind %0d seg %02h digits %05b",
                         $time, got.result_kind, got.segment_drive, got.digit_enable);
        end else begin
            want = scan_results_q.pop_front();
            if (got.result_kind !== want.result_kind ||
                got.segment_drive !== want.segment_drive ||
                got.digit_enable !== want.digit_enable) begin
                fails++;
                if (fails <= REPORT_LIMIT)
                    $display("%0t: result differs: expected kind %0d seg %02h digits %05b, %s",
                             $time, want.result_kind, want.segment_drive, want.digit_enable,
                             $sformatf("got kind %0d seg %02h digits %05b",
                                       got.result_kind, got.segment_drive, got.digit_enable));
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            reset_display();
            scan_results_q.delete();
        end else begin
            if (cfg_wr_en) dwell_ticks = cfg_wr_data;
            if (m_valid && m_ready) compare_result(m_data);
            if (s_valid && s_ready) predict_request(s_data);
        end
        expected_left <= scan_results_q.size();
    end

endmodule

// ----- tb/seven_segment_message_scanner_tb.sv -----
module seven_segment_message_scanner_tb;
    import ssms_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 4;
    localparam int IDLE_PERCENT   = 8;
    localparam int TICK_PERCENT   = 20;
    localparam int NOISE_PERCENT  = 15;
    localparam int RANDOM_ITEMS   = 500;
    localparam int PHASES         = 6;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int GLYPH_COUNT    = 30;
    localparam int COLON_GLYPH    = 2;
    localparam int DEGREE_GLYPH   = 3;
    localparam int LONG_MIN       = 12;
    localparam int LONG_MAX       = 14;

    // ways a random message gets broken on purpose
    localparam int MUT_FIFTH      = 0;
    localparam int MUT_BROKEN_DEG = 1;
    localparam int MUT_TOO_LONG   = 2;
    localparam int MUT_BAD_CHAR   = 3;
    localparam int MUT_RANGE      = 9;

    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_DEG_LEAD = 8'd194;
    localparam logic [7:0] CH_DEG_TAIL = 8'd176;

    // every character the display knows
    localparam logic [8*GLYPH_COUNT-1:0] GLYPH_TEXT = "0123456789ABCDEFGHIJLNOPQSUY_ ";

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [DWELL_W-1:0] cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    in_item_t           s_data;
    logic               m_valid;
    logic               m_ready;
    out_item_t          m_data;

    int mismatch_count;
    int expected_left;
    int stall_cycles = 0;
    int items_sent   = 0;
    bit idling_on    = 1'b1;

    // dwell settings per random phase, one of them filled in at random
    int dwell_plan [PHASES] = '{1, 65535, 3, 2, 0, 0};

    in_item_t msg_q [$];

    seven_segment_message_scanner i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    seven_segment_message_scanner_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .mismatch_count (mismatch_count),
        .expected_left  (expected_left)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // result side: stalls now and then unless idling is switched off
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= !(idling_on && $urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    // watchdog: cycles in a row without any transaction on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    function automatic in_item_t byte_item(input logic [7:0] b, input logic last);
        in_item_t it;
        it.req_type     = REQ_BYTE;
        it.message_byte = b;
        it.last_byte    = last;
        return it;
    endfunction

    // tick with junk in the fields it does not use
    function automatic in_item_t tick_item();
        in_item_t it;
        it.req_type     = REQ_TICK;
        it.message_byte = 8'($urandom_range(0, 255));
        it.last_byte    = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic void push_byte(input logic [7:0] b);
        msg_q.push_back(byte_item(b, 1'b0));
    endfunction

    function automatic logic [7:0] pick_glyph();
        int i;
        i = $urandom_range(0, GLYPH_COUNT - 1);
        return GLYPH_TEXT[8 * (GLYPH_COUNT - 1 - i) +: 8];
    endfunction

    // present one transaction at the falling edge, hold it until taken
    task automatic send_item(input in_item_t it);
        while (idling_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
    endtask

    // message bytes plus the closing last byte, with ticks mixed in
    task automatic send_message(input logic [7:0] last_value);
        msg_q.push_back(byte_item(last_value, 1'b1));
        foreach (msg_q[i]) begin
            if ($urandom_range(0, 99) < TICK_PERCENT) send_item(tick_item());
            send_item(msg_q[i]);
        end
        msg_q.delete();
    endtask

    // let every expected result come back, then leave the block alone a bit
    task automatic drain();
        s_valid <= 1'b0;
        while (expected_left != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_dwell(input logic [DWELL_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic run_directed();
        // tick on a blank display, unused fields at their top values
        send_item('{req_type: REQ_TICK, message_byte: 8'hFF, last_byte: 1'b1});
        // empty message is valid
        send_message(CH_NUL);
        // all four glyphs with dot, colon and degree sign
        push_byte("A");
        push_byte(CH_DOT);
        push_byte("_");
        push_byte(CH_COLON);
        push_byte("3");
        push_byte(CH_DEG_LEAD);
        push_byte(CH_DEG_TAIL);
        push_byte("Y");
        send_message(8'hFF);
        repeat (3) send_item(tick_item());
        // degree lead byte without its tail
        push_byte("0");
        push_byte("1");
        push_byte("2");
        push_byte(CH_DEG_LEAD);
        push_byte("3");
        send_message(CH_NUL);
        // fifth glyph
        push_byte("U");
        push_byte("N");
        push_byte("L");
        push_byte("O");
        push_byte("P");
        send_message(CH_NUL);
        // zero byte ends the text, then the junk behind it makes it too long
        push_byte("7");
        push_byte(CH_NUL);
        repeat (10) push_byte(8'hFF);
        send_message(CH_NUL);
    endtask

    task automatic build_message();
        int flavor;
        int mutation;
        int glyphs;
        int target;
        int pos;
        flavor   = $urandom_range(0, 99);
        mutation = $urandom_range(0, MUT_RANGE);
        if (flavor < NOISE_PERCENT) begin
            // raw noise
            repeat ($urandom_range(0, LONG_MAX)) push_byte(8'($urandom_range(0, 255)));
        end else begin
            glyphs = (mutation == MUT_FIFTH || mutation == MUT_BROKEN_DEG) ?
                     GLYPHS_MAX : $urandom_range(0, GLYPHS_MAX);
            for (int g = 0; g < glyphs; g++) begin
                if (g == COLON_GLYPH && $urandom_range(0, 2) == 0)
                    repeat ($urandom_range(1, 2)) push_byte(CH_COLON);
                if (g == DEGREE_GLYPH && mutation == MUT_BROKEN_DEG) begin
                    push_byte(CH_DEG_LEAD);
                    push_byte(8'($urandom_range(0, 255)));
                end else if (g == DEGREE_GLYPH && $urandom_range(0, 2) == 0) begin
                    repeat ($urandom_range(1, 2)) begin
                        push_byte(CH_DEG_LEAD);
                        push_byte(CH_DEG_TAIL);
                    end
                end
                push_byte(pick_glyph());
                if ($urandom_range(0, 2) == 0) push_byte(CH_DOT);
            end
            if (mutation == MUT_FIFTH) push_byte(pick_glyph());
            if ($urandom_range(0, 4) == 0) begin
                push_byte(CH_NUL);
                repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(0, 255)));
            end
            if (mutation == MUT_TOO_LONG) begin
                push_byte(CH_NUL);
                target = $urandom_range(LONG_MIN, LONG_MAX);
                while (msg_q.size() < target) push_byte(8'($urandom_range(0, 255)));
            end
            if (mutation == MUT_BAD_CHAR && msg_q.size() > 0) begin
                pos = $urandom_range(0, msg_q.size() - 1);
                msg_q[pos].message_byte = 8'($urandom_range(0, 255));
            end
        end
    endtask

    task automatic send_random_traffic();
        repeat ($urandom_range(0, 4)) send_item(tick_item());
        build_message();
        send_message(8'($urandom_range(0, 255)));
    endtask

    initial begin
        int directed_items;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_data      = '0;
        dwell_plan[PHASES - 1] = $urandom_range(4, 9);

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // dwell of zero has to behave like one
        write_dwell('0);
        run_directed();
        directed_items = items_sent;

        for (int p = 0; p < PHASES; p++) begin
            // sender holds off until the display has answered everything
            drain();
            write_dwell(DWELL_W'(dwell_plan[p]));
            // one phase runs flat out on both sides
            idling_on = (p != 2);
            while (items_sent < directed_items + (p + 1) * RANDOM_ITEMS / PHASES)
                send_random_traffic();
        end

        drain();
        repeat (SETTLE_CYCLES) @(negedge aclk);

        if (mismatch_count == 0 && expected_left == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
